FILE: src/ddcv_pkg.sv
// Shared types and constants for the DDC/CI VCP responder.
`default_nettype none

package ddcv_pkg;

    localparam logic [3:0] MODE_BEGIN_WRITE = 4'd0;
    localparam logic [3:0] MODE_BEGIN_READ  = 4'd1;
    localparam logic [3:0] MODE_WRITE_BYTE  = 4'd2;
    localparam logic [3:0] MODE_READ_BYTE   = 4'd3;
    localparam logic [3:0] MODE_ADVANCE     = 4'd4;
    localparam logic [3:0] MODE_END         = 4'd5;
    localparam logic [3:0] MODE_SET_BRIGHT  = 4'd6;
    localparam logic [3:0] MODE_TAKE_BRIGHT = 4'd7;
    localparam logic [3:0] MODE_TAKE_POWER  = 4'd8;

    localparam logic [2:0] CFG_BRIGHT_LIMIT = 3'd0;
    localparam logic [2:0] CFG_INIT_BRIGHT  = 3'd1;
    localparam logic [2:0] CFG_BRIGHT_CODE  = 3'd2;
    localparam logic [2:0] CFG_POWER_CODE   = 3'd3;
    localparam logic [2:0] CFG_POWER_ON     = 3'd4;
    localparam logic [2:0] CFG_POWER_OFF    = 3'd5;

    localparam logic [7:0] RST_BRIGHT_LIMIT = 8'd100;
    localparam logic [7:0] RST_INIT_BRIGHT  = 8'd50;
    localparam logic [7:0] RST_BRIGHT_CODE  = 8'h10;
    localparam logic [7:0] RST_POWER_CODE   = 8'hD6;
    localparam logic [7:0] RST_POWER_ON     = 8'd1;
    localparam logic [7:0] RST_POWER_OFF    = 8'd5;
    localparam logic [7:0] RST_BRIGHTNESS   =
        (RST_INIT_BRIGHT > RST_BRIGHT_LIMIT) ? RST_BRIGHT_LIMIT : RST_INIT_BRIGHT;

    localparam logic [7:0] HOST_ADDR   = 8'h51;
    localparam logic [7:0] RX_SEED     = 8'h6E;
    localparam logic [7:0] TX_SEED     = 8'h50;
    localparam logic [7:0] DISP_ADDR   = 8'h6E;
    localparam logic [7:0] LEN_VCP     = 8'h88;
    localparam logic [7:0] LEN_NULL    = 8'h80;
    localparam logic [7:0] OP_GET_RPL  = 8'h02;
    localparam logic [7:0] OP_GET      = 8'h01;
    localparam logic [7:0] OP_SET      = 8'h03;
    localparam logic [6:0] LEN_MASK    = 7'h7F;
    localparam logic [7:0] NULL_CHK    = TX_SEED ^ DISP_ADDR ^ LEN_NULL;
    localparam logic [7:0] VCP_CHK_FIX = TX_SEED ^ DISP_ADDR ^ LEN_VCP ^ OP_GET_RPL;

    localparam int         HDR_BYTES   = 6;
    localparam int         TX_W        = 4;
    localparam logic [TX_W-1:0] TX_LEN_NULL = TX_W'(3);
    localparam logic [TX_W-1:0] TX_LEN_VCP  = TX_W'(11);

    typedef struct packed {
        logic [7:0] bright_limit;
        logic [7:0] bright_code;
        logic [7:0] power_code;
        logic [7:0] power_on;
        logic [7:0] power_off;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] value;
    } load_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] mode;
        logic [7:0] data;
    } stage_t;

    function automatic logic [7:0] reply_byte(
        input logic [TX_W-1:0] pos,
        input logic            vcp,
        input logic [7:0]      code,
        input logic [7:0]      maxv,
        input logic [7:0]      cur,
        input logic [7:0]      chk
    );
        logic [7:0] b;
        case (pos)
            TX_W'(0):  b = DISP_ADDR;
            TX_W'(1):  b = vcp ? LEN_VCP : LEN_NULL;
            TX_W'(2):  b = vcp ? OP_GET_RPL : chk;
            TX_W'(4):  b = code;
            TX_W'(7):  b = maxv;
            TX_W'(9):  b = cur;
            TX_W'(10): b = chk;
            default:   b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: src/ddcv_if.sv
// Channel interfaces: input events, results and register writes.
`default_nettype none

interface ddcv_item_if;
    logic       valid;
    logic       ready;
    logic [3:0] mode;
    logic [7:0] data;
    modport source (output valid, output mode, output data, input ready);
    modport sink (input valid, input mode, input data, output ready);
endinterface

interface ddcv_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       write_accepted;
    logic       update_taken;
    logic [7:0] brightness;
    logic [7:0] power_mode;
    logic       brightness_pending;
    logic       power_pending;
    modport source (output valid, output read_data, output write_accepted,
                    output update_taken, output brightness, output power_mode,
                    output brightness_pending, output power_pending, input ready);
    modport sink (input valid, input read_data, input write_accepted,
                  input update_taken, input brightness, input power_mode,
                  input brightness_pending, input power_pending, output ready);
endinterface

interface ddcv_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/ddc_ci_vcp_responder.sv
// Top level of the DDC/CI VCP responder (display side, byte-level events).
// Path: an accepted event passes the input register, then the result register.
// Throughput: one event per cycle while the result sink is ready; the single
// event-to-state path sets it.
// Reset: async active low; state registers take defaults, brightness 50, power 1.
`default_nettype none

module ddc_ci_vcp_responder
    import ddcv_pkg::*;
#(
    parameter int RX_DEPTH = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    ddcv_cfg_if.sink      cfg,
    ddcv_item_if.sink     item,
    ddcv_result_if.source result
);

    cfg_t   cfg_vals;
    load_t  bright_load;
    stage_t stage;
    logic   advance;

    ddcv_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cfg_vals    (cfg_vals),
        .bright_load (bright_load)
    );

    ddcv_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .stage   (stage)
    );

    ddcv_engine #(
        .RX_DEPTH (RX_DEPTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage       (stage),
        .advance     (advance),
        .cfg_vals    (cfg_vals),
        .bright_load (bright_load),
        .result      (result)
    );

    a_take_clears_one: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.update_taken
        |-> !(result.brightness_pending && result.power_pending))
        else $error("take transaction left both updates pending");

    a_write_or_take: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.write_accepted && result.update_taken))
        else $error("write and take reported together");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> stage.valid)
        else $error("accepted transaction missing from input register");

endmodule

`default_nettype wire

FILE: src/ddcv_cfg.sv
// Configuration register file.
`default_nettype none

module ddcv_cfg
    import ddcv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    ddcv_cfg_if.sink     cfg,
    output cfg_t         cfg_vals,
    output load_t        bright_load
);

    logic [7:0] bright_limit_reg;
    logic [7:0] bright_code_reg;
    logic [7:0] power_code_reg;
    logic [7:0] power_on_reg;
    logic [7:0] power_off_reg;
    logic       wr;

    assign cfg.ready = 1'b1;
    assign wr = cfg.valid & cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_limit_reg <= RST_BRIGHT_LIMIT;
            bright_code_reg  <= RST_BRIGHT_CODE;
            power_code_reg   <= RST_POWER_CODE;
            power_on_reg     <= RST_POWER_ON;
            power_off_reg    <= RST_POWER_OFF;
        end
        else if (wr)
        begin
            case (cfg.index)
                CFG_BRIGHT_LIMIT: bright_limit_reg <= cfg.data;
                CFG_INIT_BRIGHT:  ;
                CFG_BRIGHT_CODE:  bright_code_reg  <= cfg.data;
                CFG_POWER_CODE:   power_code_reg   <= cfg.data;
                CFG_POWER_ON:     power_on_reg     <= cfg.data;
                CFG_POWER_OFF:    power_off_reg    <= cfg.data;
                default:          ;
            endcase
        end
    end

    // initial brightness only reloads the live level (clamped downstream)
    assign bright_load.valid = wr && (cfg.index == CFG_INIT_BRIGHT);
    assign bright_load.value = cfg.data;

    assign cfg_vals.bright_limit = bright_limit_reg;
    assign cfg_vals.bright_code  = bright_code_reg;
    assign cfg_vals.power_code   = power_code_reg;
    assign cfg_vals.power_on     = power_on_reg;
    assign cfg_vals.power_off    = power_off_reg;

endmodule

`default_nettype wire

FILE: src/ddcv_in_stage.sv
// Input register stage for bus and local events.
`default_nettype none

module ddcv_in_stage
    import ddcv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    ddcv_item_if.sink    item,
    input  wire logic    advance,
    output stage_t       stage
);

    logic       valid_reg;
    logic [3:0] mode_reg;
    logic [7:0] data_reg;
    logic       load;

    assign item.ready = !valid_reg || advance;
    assign load = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mode_reg <= item.mode;
            data_reg <= item.data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.mode  = mode_reg;
    assign stage.data  = data_reg;

endmodule

`default_nettype wire

FILE: src/ddcv_engine.sv
// Protocol state, packet check, reply build and result register.
`default_nettype none

module ddcv_engine
    import ddcv_pkg::*;
#(
    parameter int RX_DEPTH = 32
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire stage_t  stage,
    output logic         advance,
    input  wire cfg_t    cfg_vals,
    input  wire load_t   bright_load,
    ddcv_result_if.source result
);

    localparam int CW = $clog2(RX_DEPTH + 1);

    logic [7:0]      hdr_reg [HDR_BYTES];
    logic [CW-1:0]   rx_count_reg, rx_count_next;
    logic [7:0]      rx_xor_reg, rx_xor_next;
    logic [TX_W-1:0] tx_count_reg, tx_count_next;
    logic [TX_W-1:0] tx_pos_reg, tx_pos_next;
    logic            reply_ready_reg, reply_ready_next;
    logic            reading_reg, reading_next;
    logic            vcp_reg, vcp_next;
    logic [7:0]      rcode_reg, rcode_next;
    logic [7:0]      rmax_reg, rmax_next;
    logic [7:0]      rcur_reg, rcur_next;
    logic [7:0]      rchk_reg, rchk_next;
    logic [7:0]      bright_reg, bright_next;
    logic            bflag_reg, bflag_next;
    logic [7:0]      power_reg, power_next;
    logic            pflag_reg, pflag_next;

    logic            out_valid_reg;
    logic [7:0]      read_data_reg;
    logic            accepted_reg;
    logic            taken_reg;

    logic            fire;
    logic            hdr_wr;
    logic            accepted, taken;
    logic [7:0]      len_field;
    logic            pkt_ok, is_get, is_set;
    logic            code_b, code_p;
    logic [7:0]      set_bright;
    logic            power_in_range;
    logic [7:0]      rd_next;

    assign advance = !out_valid_reg || result.ready;
    assign fire    = stage.valid && advance;

    assign len_field = {1'b0, hdr_reg[1][6:0] & LEN_MASK} + 8'd3;
    assign pkt_ok = (rx_count_reg >= CW'(4)) && (hdr_reg[0] == HOST_ADDR)
                 && hdr_reg[1][7] && (8'(rx_count_reg) == len_field)
                 && (rx_xor_reg == RX_SEED);
    assign is_get = pkt_ok && (hdr_reg[2] == OP_GET) && (rx_count_reg == CW'(5));
    assign is_set = pkt_ok && (hdr_reg[2] == OP_SET) && (rx_count_reg == CW'(7));
    assign code_b = (hdr_reg[3] == cfg_vals.bright_code);
    assign code_p = (hdr_reg[3] == cfg_vals.power_code);
    assign set_bright = ((hdr_reg[4] != 8'h00) || (hdr_reg[5] > cfg_vals.bright_limit))
                      ? cfg_vals.bright_limit : hdr_reg[5];
    assign power_in_range = (hdr_reg[5] >= cfg_vals.power_on)
                         && (hdr_reg[5] <= cfg_vals.power_off);

    assign hdr_wr = fire && (stage.mode == MODE_WRITE_BYTE)
                 && (rx_count_reg < CW'(HDR_BYTES));

    always_comb
    begin
        rx_count_next    = rx_count_reg;
        rx_xor_next      = rx_xor_reg;
        tx_count_next    = tx_count_reg;
        tx_pos_next      = tx_pos_reg;
        reply_ready_next = reply_ready_reg;
        reading_next     = reading_reg;
        vcp_next         = vcp_reg;
        rcode_next       = rcode_reg;
        rmax_next        = rmax_reg;
        rcur_next        = rcur_reg;
        rchk_next        = rchk_reg;
        bright_next      = bright_reg;
        bflag_next       = bflag_reg;
        power_next       = power_reg;
        pflag_next       = pflag_reg;
        accepted         = 1'b0;
        taken            = 1'b0;

        if (fire)
        begin
            case (stage.mode)
                MODE_BEGIN_WRITE:
                begin
                    reading_next  = 1'b0;
                    rx_count_next = '0;
                    rx_xor_next   = 8'h00;
                end
                MODE_BEGIN_READ:
                begin
                    reading_next = 1'b1;
                    if (!reply_ready_reg)
                    begin
                        vcp_next         = 1'b0;
                        rchk_next        = NULL_CHK;
                        tx_count_next    = TX_LEN_NULL;
                        reply_ready_next = 1'b1;
                    end
                    tx_pos_next = '0;
                end
                MODE_WRITE_BYTE:
                begin
                    if (rx_count_reg < CW'(RX_DEPTH))
                    begin
                        rx_count_next = rx_count_reg + CW'(1);
                        rx_xor_next   = rx_xor_reg ^ stage.data;
                        accepted      = 1'b1;
                    end
                end
                MODE_ADVANCE:
                begin
                    if (tx_pos_reg < tx_count_reg)
                    begin
                        tx_pos_next = tx_pos_reg + TX_W'(1);
                    end
                end
                MODE_END:
                begin
                    if (reading_reg)
                    begin
                        reply_ready_next = 1'b0;
                        tx_pos_next      = '0;
                    end
                    else if (rx_count_reg != '0)
                    begin
                        tx_pos_next      = '0;
                        reply_ready_next = 1'b1;
                        if (is_get && (code_b || code_p))
                        begin
                            vcp_next      = 1'b1;
                            rcode_next    = hdr_reg[3];
                            rmax_next     = code_b ? cfg_vals.bright_limit
                                                   : cfg_vals.power_off;
                            rcur_next     = code_b ? bright_reg : power_reg;
                            rchk_next     = VCP_CHK_FIX ^ hdr_reg[3] ^ rmax_next
                                          ^ rcur_next;
                            tx_count_next = TX_LEN_VCP;
                        end
                        else
                        begin
                            vcp_next      = 1'b0;
                            rchk_next     = NULL_CHK;
                            tx_count_next = TX_LEN_NULL;
                        end
                        if (is_set && code_b)
                        begin
                            bright_next = set_bright;
                            bflag_next  = 1'b1;
                        end
                        else if (is_set && code_p && power_in_range)
                        begin
                            power_next = hdr_reg[5];
                            pflag_next = 1'b1;
                        end
                    end
                end
                MODE_SET_BRIGHT:
                begin
                    bright_next = (stage.data > cfg_vals.bright_limit)
                                ? cfg_vals.bright_limit : stage.data;
                end
                MODE_TAKE_BRIGHT:
                begin
                    if (bflag_reg)
                    begin
                        bflag_next = 1'b0;
                        taken      = 1'b1;
                    end
                end
                MODE_TAKE_POWER:
                begin
                    if (pflag_reg)
                    begin
                        pflag_next = 1'b0;
                        taken      = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (bright_load.valid)
        begin
            bright_next = (bright_load.value > cfg_vals.bright_limit)
                        ? cfg_vals.bright_limit : bright_load.value;
        end
    end

    assign rd_next = (tx_pos_next < tx_count_next)
                   ? reply_byte(tx_pos_next, vcp_next, rcode_next, rmax_next,
                                rcur_next, rchk_next)
                   : 8'h00;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg    <= '0;
            rx_xor_reg      <= 8'h00;
            tx_count_reg    <= '0;
            tx_pos_reg      <= '0;
            reply_ready_reg <= 1'b0;
            reading_reg     <= 1'b0;
            bright_reg      <= RST_BRIGHTNESS;
            bflag_reg       <= 1'b0;
            power_reg       <= RST_POWER_ON;
            pflag_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            rx_count_reg    <= rx_count_next;
            rx_xor_reg      <= rx_xor_next;
            tx_count_reg    <= tx_count_next;
            tx_pos_reg      <= tx_pos_next;
            reply_ready_reg <= reply_ready_next;
            reading_reg     <= reading_next;
            bright_reg      <= bright_next;
            bflag_reg       <= bflag_next;
            power_reg       <= power_next;
            pflag_reg       <= pflag_next;
            out_valid_reg   <= fire || (out_valid_reg && !result.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        vcp_reg   <= vcp_next;
        rcode_reg <= rcode_next;
        rmax_reg  <= rmax_next;
        rcur_reg  <= rcur_next;
        rchk_reg  <= rchk_next;
        if (hdr_wr)
        begin
            hdr_reg[rx_count_reg[2:0]] <= stage.data;
        end
        if (fire)
        begin
            read_data_reg <= rd_next;
            accepted_reg  <= accepted;
            taken_reg     <= taken;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.read_data          = read_data_reg;
    assign result.write_accepted     = accepted_reg;
    assign result.update_taken       = taken_reg;
    assign result.brightness         = bright_reg;
    assign result.power_mode         = power_reg;
    assign result.brightness_pending = bflag_reg;
    assign result.power_pending      = pflag_reg;

endmodule

`default_nettype wire

FILE: tb/ddc_ci_vcp_responder_tb.sv
// Self-checking testbench for the DDC/CI VCP responder: host packets, reads, local events.
`timescale 1ns / 100ps

module ddc_ci_vcp_responder_tb
    import ddcv_pkg::*;
;

    localparam int         PERIOD          = 10;
    localparam int         RX_LIMIT        = 32;
    localparam int         TX_SLOTS        = 16;
    localparam int         LATENCY         = 2;
    localparam int         RANDOM_EVENTS   = 1150;
    localparam int         PHASE_EVENTS    = 230;
    localparam int         HOLD_CYCLES     = 250;
    localparam int         LIMIT_CYCLES    = 200000;
    localparam logic [3:0] MODE_NONE_FIRST = 4'd9;
    localparam logic [3:0] MODE_NONE_LAST  = 4'd15;

    typedef struct packed {
        logic [7:0] read_data;
        logic       write_accepted;
        logic       update_taken;
        logic [7:0] brightness;
        logic [7:0] power_mode;
        logic       brightness_pending;
        logic       power_pending;
    } vcp_result_t;

    class vcp_checker;
        logic [7:0]  bright_limit, init_bright, bright_code;
        logic [7:0]  power_code, power_on, power_off;
        logic [7:0]  rx_bytes [RX_LIMIT];
        int unsigned rx_len;
        logic [7:0]  rx_sum;
        logic [7:0]  tx_bytes [TX_SLOTS];
        int unsigned tx_len, tx_idx;
        bit          have_reply, in_read;
        logic [7:0]  level, pmode;
        bit          level_flag, pmode_flag;
        vcp_result_t pending_results [$];
        int          errors, checked, vcp_built, null_built, drops;

        function new();
            bright_limit = RST_BRIGHT_LIMIT;
            init_bright  = RST_INIT_BRIGHT;
            bright_code  = RST_BRIGHT_CODE;
            power_code   = RST_POWER_CODE;
            power_on     = RST_POWER_ON;
            power_off    = RST_POWER_OFF;
            rx_len       = 0;
            rx_sum       = 8'h00;
            tx_len       = 0;
            tx_idx       = 0;
            have_reply   = 1'b0;
            in_read      = 1'b0;
            level        = RST_BRIGHTNESS;
            pmode        = RST_POWER_ON;
            level_flag   = 1'b0;
            pmode_flag   = 1'b0;
            errors       = 0;
            checked      = 0;
            vcp_built    = 0;
            null_built   = 0;
            drops        = 0;
        endfunction

        function logic [7:0] clamp(logic [7:0] v);
            return (v > bright_limit) ? bright_limit : v;
        endfunction

        function void load_reg(logic [2:0] idx, logic [7:0] v);
            case (idx)
                CFG_BRIGHT_LIMIT: bright_limit = v;
                CFG_INIT_BRIGHT:
                begin
                    init_bright = v;
                    level       = clamp(v);
                end
                CFG_BRIGHT_CODE:  bright_code = v;
                CFG_POWER_CODE:   power_code = v;
                CFG_POWER_ON:     power_on = v;
                CFG_POWER_OFF:    power_off = v;
                default: ;
            endcase
        endfunction

        function void seal_reply(int unsigned n);
            logic [7:0] chk;
            chk = TX_SEED;
            for (int unsigned i = 0; i + 1 < n; i++)
                chk ^= tx_bytes[i];
            tx_bytes[n-1] = chk;
            tx_len        = n;
            tx_idx        = 0;
            have_reply    = 1'b1;
        endfunction

        function void null_reply();
            tx_bytes[0] = DISP_ADDR;
            tx_bytes[1] = LEN_NULL;
            seal_reply(3);
            null_built++;
        endfunction

        function void vcp_reply(logic [7:0] code, logic [7:0] maxv, logic [7:0] cur);
            tx_bytes[0] = DISP_ADDR;
            tx_bytes[1] = LEN_VCP;
            tx_bytes[2] = OP_GET_RPL;
            tx_bytes[3] = 8'h00;
            tx_bytes[4] = code;
            tx_bytes[5] = 8'h00;
            tx_bytes[6] = 8'h00;
            tx_bytes[7] = maxv;
            tx_bytes[8] = 8'h00;
            tx_bytes[9] = cur;
            seal_reply(11);
            vcp_built++;
        endfunction

        function bit packet_valid();
            if (rx_len < 4)
                return 1'b0;
            if (rx_bytes[0] != HOST_ADDR)
                return 1'b0;
            if (!rx_bytes[1][7])
                return 1'b0;
            if (rx_len != int'(rx_bytes[1][6:0]) + 3)
                return 1'b0;
            return (rx_sum ^ RX_SEED) == 8'h00;
        endfunction

        function void run_packet();
            logic [15:0] req;
            logic [7:0]  code;
            if (!packet_valid())
            begin
                null_reply();
                return;
            end
            code = rx_bytes[3];
            if (rx_bytes[2] == OP_GET && rx_len == 5)
            begin
                if (code == bright_code)
                    vcp_reply(code, bright_limit, level);
                else if (code == power_code)
                    vcp_reply(code, power_off, pmode);
                else
                    null_reply();
                return;
            end
            if (rx_bytes[2] == OP_SET && rx_len == 7)
            begin
                if (code == bright_code)
                begin
                    req        = {rx_bytes[4], rx_bytes[5]};
                    level      = (req > {8'h00, bright_limit}) ? bright_limit : rx_bytes[5];
                    level_flag = 1'b1;
                end
                else if (code == power_code)
                begin
                    // only the low value byte counts; out of range is ignored
                    if (rx_bytes[5] >= power_on && rx_bytes[5] <= power_off)
                    begin
                        pmode      = rx_bytes[5];
                        pmode_flag = 1'b1;
                    end
                end
            end
            null_reply();
        endfunction

        function void note_event(logic [3:0] m, logic [7:0] d);
            vcp_result_t r;
            r = '0;
            case (m)
                MODE_BEGIN_WRITE:
                begin
                    in_read = 1'b0;
                    rx_len  = 0;
                    rx_sum  = 8'h00;
                end
                MODE_BEGIN_READ:
                begin
                    in_read = 1'b1;
                    if (!have_reply)
                        null_reply();
                    tx_idx = 0;
                end
                MODE_WRITE_BYTE:
                begin
                    if (rx_len < RX_LIMIT)
                    begin
                        rx_bytes[rx_len] = d;
                        rx_len++;
                        rx_sum ^= d;
                        r.write_accepted = 1'b1;
                    end
                    else
                        drops++;
                end
                MODE_ADVANCE:
                begin
                    if (tx_idx < tx_len)
                        tx_idx++;
                end
                MODE_END:
                begin
                    if (in_read)
                    begin
                        have_reply = 1'b0;
                        tx_idx     = 0;
                    end
                    else if (rx_len > 0)
                        run_packet();
                end
                MODE_SET_BRIGHT:  level = clamp(d);
                MODE_TAKE_BRIGHT:
                begin
                    if (level_flag)
                    begin
                        level_flag     = 1'b0;
                        r.update_taken = 1'b1;
                    end
                end
                MODE_TAKE_POWER:
                begin
                    if (pmode_flag)
                    begin
                        pmode_flag     = 1'b0;
                        r.update_taken = 1'b1;
                    end
                end
                default: ;
            endcase
            r.read_data          = (tx_idx < tx_len) ? tx_bytes[tx_idx] : 8'h00;
            r.brightness         = level;
            r.power_mode         = pmode;
            r.brightness_pending = level_flag;
            r.power_pending      = pmode_flag;
            pending_results.push_back(r);
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            $display("MISMATCH %s at result %0d: got %0h, want %0h", what, checked, got, want);
            errors++;
        endtask

        task check_result(vcp_result_t got);
            vcp_result_t want;
            if (pending_results.size() == 0)
            begin
                report("result with no transaction outstanding", got.read_data, 8'h00);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.read_data != want.read_data)
                report("read_data", got.read_data, want.read_data);
            if (got.write_accepted != want.write_accepted)
                report("write_accepted", got.write_accepted, want.write_accepted);
            if (got.update_taken != want.update_taken)
                report("update_taken", got.update_taken, want.update_taken);
            if (got.brightness != want.brightness)
                report("brightness", got.brightness, want.brightness);
            if (got.power_mode != want.power_mode)
                report("power_mode", got.power_mode, want.power_mode);
            if (got.brightness_pending != want.brightness_pending)
                report("brightness_pending", got.brightness_pending, want.brightness_pending);
            if (got.power_pending != want.power_pending)
                report("power_pending", got.power_pending, want.power_pending);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    bit          calm;
    bit          hold_go;
    int          hold_count;
    int          cycles;
    int          events_sent;
    int          phases;
    logic [7:0]  pkt [$];
    vcp_checker  sb = new();

    ddcv_item_if   item ();
    ddcv_result_if result ();
    ddcv_cfg_if    cfg ();

    ddc_ci_vcp_responder #(
        .RX_DEPTH(RX_LIMIT)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .item(item),
        .result(result)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d transactions outstanding",
                     cycles, sb.pending_results.size());
            $display("ddc_ci_vcp_responder_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        vcp_result_t got;
        if (rst_n && result.valid && result.ready)
        begin
            got.read_data          = result.read_data;
            got.write_accepted     = result.write_accepted;
            got.update_taken       = result.update_taken;
            got.brightness         = result.brightness;
            got.power_mode         = result.power_mode;
            got.brightness_pending = result.brightness_pending;
            got.power_pending      = result.power_pending;
            sb.check_result(got);
        end
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        result.ready = 1'b0;
        hold_count   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_go && hold_count < HOLD_CYCLES)
            begin
                hold_count++;
                result.ready = 1'b0;
            end
            else
                result.ready = calm || ($urandom_range(99) >= 7);
        end
    end

    task automatic send_item(input logic [3:0] m, input logic [7:0] d);
        while (!calm && $urandom_range(99) < 7)
        begin
            item.valid = 1'b0;
            @(negedge clk);
        end
        item.valid = 1'b1;
        item.mode  = m;
        item.data  = d;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        sb.note_event(m, d);
        if (m <= MODE_TAKE_POWER)
            events_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        item.valid = 1'b0;
        while (sb.pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic configure(input logic [7:0] lim, input logic [7:0] ini,
                             input logic [7:0] bc, input logic [7:0] pc,
                             input logic [7:0] on, input logic [7:0] off);
        logic [2:0] regs [6];
        logic [7:0] vals [6];
        regs = '{CFG_BRIGHT_LIMIT, CFG_INIT_BRIGHT, CFG_BRIGHT_CODE,
                 CFG_POWER_CODE, CFG_POWER_ON, CFG_POWER_OFF};
        vals = '{lim, ini, bc, pc, on, off};
        drain();
        for (int k = 0; k < 6; k++)
        begin
            cfg.valid = 1'b1;
            cfg.index = regs[k];
            cfg.data  = vals[k];
            @(posedge clk);
            while (!cfg.ready)
                @(posedge clk);
            sb.load_reg(regs[k], vals[k]);
            @(negedge clk);
        end
        cfg.valid = 1'b0;
        phases++;
    endtask

    function automatic void seal_pkt();
        logic [7:0] chk;
        chk = RX_SEED;
        foreach (pkt[k])
            chk ^= pkt[k];
        pkt.push_back(chk);
    endfunction

    task automatic send_packet();
        send_item(MODE_BEGIN_WRITE, 8'($urandom));
        foreach (pkt[k])
            send_item(MODE_WRITE_BYTE, pkt[k]);
        send_item(MODE_END, 8'($urandom));
    endtask

    task automatic host_exchange();
        int         kind;
        int         n;
        logic [7:0] code, hi, lo;
        kind = $urandom_range(99);
        case ($urandom_range(4))
            0, 1:    code = sb.bright_code;
            2, 3:    code = sb.power_code;
            default: code = 8'($urandom);
        endcase
        hi = ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00;
        lo = $urandom_range(1) ? 8'($urandom)
                               : 8'($urandom_range(sb.power_on, sb.power_off)
                                    + $urandom_range(2) - 1);
        if (kind < 40)
            pkt = {HOST_ADDR, 8'h82, OP_GET, code};
        else if (kind < 80)
            pkt = {HOST_ADDR, 8'h84, OP_SET, code, hi, lo};
        else
        begin
            // well-framed but odd length or unknown command
            n   = $urandom_range(0, 7);
            pkt = {HOST_ADDR, 8'h80 | 8'(n)};
            if (n > 0 && $urandom_range(1))
                pkt.push_back($urandom_range(1) ? OP_GET : OP_SET);
            while (pkt.size() < n + 2)
                pkt.push_back(8'($urandom));
        end
        seal_pkt();
        if ((kind >= 80) ? ($urandom_range(2) == 0) : ($urandom_range(9) == 0))
        begin
            n = $urandom_range(0, pkt.size() - 1);
            pkt[n] ^= 8'($urandom_range(1, 255));
        end
        send_packet();
        if ($urandom_range(9) != 0)
        begin
            send_item(MODE_BEGIN_READ, 8'($urandom));
            repeat ($urandom_range(0, 13))
            begin
                send_item(MODE_READ_BYTE, 8'($urandom));
                send_item(MODE_ADVANCE, 8'($urandom));
            end
            if ($urandom_range(9) != 0)
                send_item(MODE_END, 8'($urandom));
        end
    endtask

    initial
    begin
        int  base;
        int  done;
        int  next_phase;
        int  pick;
        bit  paused;
        logic [7:0] on;
        rst_n       = 1'b0;
        item.valid  = 1'b0;
        item.mode   = MODE_BEGIN_WRITE;
        item.data   = 8'h00;
        cfg.valid   = 1'b0;
        cfg.index   = CFG_BRIGHT_LIMIT;
        cfg.data    = 8'h00;
        calm        = 1'b0;
        hold_go     = 1'b0;
        cycles      = 0;
        events_sent = 0;
        phases      = 0;
        paused      = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset settings
        send_item(MODE_ADVANCE, 8'h00);
        send_item(MODE_BEGIN_READ, 8'hFF);
        send_item(MODE_READ_BYTE, 8'h00);
        repeat (4) send_item(MODE_ADVANCE, 8'hA5);
        send_item(MODE_END, 8'h5A);
        send_item(MODE_BEGIN_WRITE, 8'h00);
        send_item(MODE_END, 8'h00);
        send_item(MODE_NONE_LAST, 8'hFF);
        send_item(MODE_NONE_FIRST, 8'h00);
        send_item(MODE_SET_BRIGHT, 8'hFF);
        send_item(MODE_SET_BRIGHT, 8'h00);
        pkt = {HOST_ADDR, 8'h84, OP_SET, RST_BRIGHT_CODE, 8'h01, 8'h00};
        seal_pkt();
        send_packet();
        send_item(MODE_TAKE_BRIGHT, 8'h00);
        send_item(MODE_TAKE_BRIGHT, 8'hFF);
        send_item(MODE_TAKE_POWER, 8'h00);

        base       = events_sent;
        next_phase = 0;
        while (events_sent - base < RANDOM_EVENTS)
        begin
            done = events_sent - base;
            if (done >= next_phase)
            begin
                on = 8'($urandom_range(0, 6));
                case (phases % 5)
                    0:       configure(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
                    1:       configure(8'h00, 8'h00, 8'h10, 8'h10, 8'hFF, 8'h00);
                    4:       configure(RST_BRIGHT_LIMIT, RST_INIT_BRIGHT, RST_BRIGHT_CODE,
                                       RST_POWER_CODE, RST_POWER_ON, RST_POWER_OFF);
                    default: configure(8'($urandom), 8'($urandom), 8'($urandom),
                                       8'($urandom), on, on + 8'($urandom_range(0, 6)));
                endcase
                next_phase += PHASE_EVENTS;
            end
            if (!hold_go && done >= 400)
                hold_go = 1'b1;
            if (!paused && done >= 900)
            begin
                drain();
                paused = 1'b1;
            end
            calm = (done >= 600 && done < 800);
            pick = $urandom_range(99);
            if (pick < 65)
                host_exchange();
            else if (pick < 78)
            begin
                case ($urandom_range(3))
                    0: send_item(MODE_SET_BRIGHT,
                                 ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom));
                    1: send_item(MODE_TAKE_BRIGHT, 8'($urandom));
                    2: send_item(MODE_TAKE_POWER, 8'($urandom));
                    default: send_item(4'($urandom_range(MODE_NONE_FIRST, MODE_NONE_LAST)),
                                       8'($urandom));
                endcase
            end
            else if (pick < 86)
            begin
                // long packets that can overrun the receive store
                pkt = {HOST_ADDR};
                repeat ($urandom_range(30, 36)) pkt.push_back(8'($urandom));
                send_packet();
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_item(4'($urandom), 8'($urandom));
            end
        end
        calm = 1'b0;

        drain();
        repeat (LATENCY + 8) @(posedge clk);
        if (sb.pending_results.size() != 0)
            sb.report("transactions left outstanding", 8'(sb.pending_results.size()), 8'h00);
        $display("Ran %0d events over %0d register settings, %0d results compared.",
                 events_sent, phases, sb.checked);
        $display("Built %0d feature replies and %0d null replies; %0d bytes hit a full store.",
                 sb.vcp_built, sb.null_built, sb.drops);
        if (sb.errors == 0)
            $display("ddc_ci_vcp_responder_tb passed");
        else
            $display("ddc_ci_vcp_responder_tb failed");
        $finish;
    end

endmodule

FILE: sim.f
src/ddcv_pkg.sv
src/ddcv_if.sv
src/ddcv_cfg.sv
src/ddcv_in_stage.sv
src/ddcv_engine.sv
src/ddc_ci_vcp_responder.sv
tb/ddc_ci_vcp_responder_tb.sv
